[hw/rtl/i2cms_pkg.sv]
// Shared constants, types and helpers of the I2C master transfer sequencer.
`default_nettype none
package i2cms_pkg;

    localparam int MAX_BYTES = 64;
    localparam int PTR_W     = $clog2(MAX_BYTES + 1);
    localparam int BUF_AW    = $clog2(MAX_BYTES);
    localparam int LEN_W     = 7;
    localparam int IDX_W     = 6;

    localparam logic [PTR_W-1:0] MAX_PTR = PTR_W'(MAX_BYTES);

    localparam logic [1:0] FUNC_LOAD     = 2'd0;
    localparam logic [1:0] FUNC_START_WR = 2'd1;
    localparam logic [1:0] FUNC_START_RD = 2'd2;
    localparam logic [1:0] FUNC_EVENT    = 2'd3;

    localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

    typedef struct packed {
        logic [1:0]       func;
        logic [7:0]       address;
        logic [LEN_W-1:0] length;
        logic [7:0]       tx_byte;
        logic             flag_start;
        logic             flag_addr;
        logic             flag_btf;
        logic             flag_txe;
        logic             flag_rxne;
        logic [7:0]       data_reg;
        logic [7:0]       data_reg_next;
    } t_item;

    typedef struct packed {
        logic [7:0]       slave_address;
        logic             is_transmit;
        logic [PTR_W-1:0] transfer_length;
        logic [PTR_W-1:0] byte_pointer;
        logic [PTR_W-1:0] load_index;
    } t_state;

    typedef struct packed {
        logic             dr_write_valid;
        logic [7:0]       dr_value;
        logic             ack_set;
        logic             ack_clear;
        logic             stop_set;
        logic             start_set;
        logic             pos_set;
        logic             released;
        logic             rx_valid;
        logic [7:0]       rx_byte;
        logic [IDX_W-1:0] rx_index;
        logic             last;
    } t_result;

    // Pointer increment that stops at the buffer size.
    function automatic logic [PTR_W-1:0] sat_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        res = (ptr < MAX_PTR) ? ptr + PTR_W'(1) : ptr;
        return res;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/i2c_master_transfer_sequencer.sv]
// Top level of the I2C master transfer sequencer.
//
// Commands and controller events enter through an input register and are decoded
// into a two-entry result register, so one item is taken every clock while the
// output side keeps up; an item with no result never waits for the output side.
// A receive BTF yields two result transfers and holds a following item that
// has results until the second transfer is taken. Write data sits in a 64-byte
// RAM whose read address follows the byte pointer, so the data for a TXE or ADDR
// event is ready when it is decoded. The RAM needs no clearing after reset.
`default_nettype none
module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [1:0]       i_func,
    input  wire logic [7:0]       i_address,
    input  wire logic [LEN_W-1:0] i_length,
    input  wire logic [7:0]       i_tx_byte,
    input  wire logic             i_flag_start,
    input  wire logic             i_flag_addr,
    input  wire logic             i_flag_btf,
    input  wire logic             i_flag_txe,
    input  wire logic             i_flag_rxne,
    input  wire logic [7:0]       i_data_reg,
    input  wire logic [7:0]       i_data_reg_next,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_dr_write_valid,
    output logic [7:0]            o_dr_value,
    output logic                  o_ack_set,
    output logic                  o_ack_clear,
    output logic                  o_stop_set,
    output logic                  o_start_set,
    output logic                  o_pos_set,
    output logic                  o_released,
    output logic                  o_rx_valid,
    output logic [7:0]            o_rx_byte,
    output logic [IDX_W-1:0]      o_rx_index,
    output logic                  o_last
);

    logic        r_in_valid;
    logic        n_in_valid;
    t_item       r_item;
    t_state      r_state;
    t_state      n_state;
    t_result     r_out0;
    t_result     r_out1;
    logic [1:0]  r_cnt;
    logic        r_fwd;
    logic [7:0]  r_fwd_data;

    t_state            w_step_state;
    t_result           w_res0;
    t_result           w_res1;
    logic [1:0]        w_nres;
    logic              w_step_we;
    logic              w_we;
    logic [BUF_AW-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic [BUF_AW-1:0] w_raddr;
    logic [7:0]        w_ram_q;
    logic [7:0]        w_buf_byte;
    logic              w_out_acc;
    logic              w_out_free;
    logic              w_fire;
    logic              w_in_take;

    assign w_buf_byte = r_fwd ? r_fwd_data : w_ram_q;

    i2cms_step u_step (
        .i_item      (r_item),
        .i_state     (r_state),
        .i_buf_byte  (w_buf_byte),
        .o_state     (w_step_state),
        .o_res0      (w_res0),
        .o_res1      (w_res1),
        .o_nres      (w_nres),
        .o_buf_we    (w_step_we),
        .o_buf_waddr (w_waddr),
        .o_buf_wdata (w_wdata)
    );

    assign w_out_acc  = (r_cnt != 2'd0) && !i_stall;
    assign w_out_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_out_acc);
    assign w_fire     = r_in_valid && ((w_nres == 2'd0) || w_out_free);
    assign o_stall    = r_in_valid && !w_fire;
    assign w_in_take  = i_valid && !o_stall;
    assign n_in_valid = w_in_take || (r_in_valid && !w_fire);

    assign n_state = w_fire ? w_step_state : r_state;
    assign w_we    = w_fire && w_step_we;
    // The RAM is read at the pointer the next item will see.
    assign w_raddr = n_state.byte_pointer[BUF_AW-1:0];

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_cnt      <= 2'd0;
            r_fwd      <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_state    <= n_state;
            // A write to the address being read is forwarded past the RAM.
            r_fwd      <= w_we && (w_waddr == w_raddr);
            if (w_fire && (w_nres != 2'd0)) begin
                r_cnt <= w_nres;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_wdata;
        if (w_in_take) begin
            r_item.func          <= i_func;
            r_item.address       <= i_address;
            r_item.length        <= i_length;
            r_item.tx_byte       <= i_tx_byte;
            r_item.flag_start    <= i_flag_start;
            r_item.flag_addr     <= i_flag_addr;
            r_item.flag_btf      <= i_flag_btf;
            r_item.flag_txe      <= i_flag_txe;
            r_item.flag_rxne     <= i_flag_rxne;
            r_item.data_reg      <= i_data_reg;
            r_item.data_reg_next <= i_data_reg_next;
        end
        if (w_fire && (w_nres != 2'd0)) begin
            r_out0 <= w_res0;
            r_out1 <= w_res1;
        end else if (w_out_acc) begin
            r_out0 <= r_out1;
        end
    end

    assign o_valid          = (r_cnt != 2'd0);
    assign o_dr_write_valid = r_out0.dr_write_valid;
    assign o_dr_value       = r_out0.dr_value;
    assign o_ack_set        = r_out0.ack_set;
    assign o_ack_clear      = r_out0.ack_clear;
    assign o_stop_set       = r_out0.stop_set;
    assign o_start_set      = r_out0.start_set;
    assign o_pos_set        = r_out0.pos_set;
    assign o_released       = r_out0.released;
    assign o_rx_valid       = r_out0.rx_valid;
    assign o_rx_byte        = r_out0.rx_byte;
    assign o_rx_index       = r_out0.rx_index;
    assign o_last           = r_out0.last;

endmodule
`default_nettype wire

[hw/rtl/i2cms_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/i2cms_step.sv]
// Decode of one command or controller event into state updates and results.
`default_nettype none
module i2cms_step
    import i2cms_pkg::*;
(
    input  wire t_item              i_item,
    input  wire t_state             i_state,
    input  wire logic [7:0]         i_buf_byte,
    output t_state                  o_state,
    output t_result                 o_res0,
    output t_result                 o_res1,
    output logic [1:0]              o_nres,
    output logic                    o_buf_we,
    output logic [BUF_AW-1:0]       o_buf_waddr,
    output logic [7:0]              o_buf_wdata
);

    logic [PTR_W-1:0] w_len;
    logic [PTR_W-1:0] w_bp1;
    logic [PTR_W-1:0] w_bp2;
    logic [PTR_W:0]   w_bp1_plus;

    always_comb begin
        w_len = (i_item.length > LEN_W'(MAX_BYTES)) ? MAX_PTR : PTR_W'(i_item.length);
        w_bp1 = sat_inc(i_state.byte_pointer);
        w_bp2 = sat_inc(w_bp1);
        w_bp1_plus = {1'b0, w_bp1} + (PTR_W+1)'(1);

        o_state     = i_state;
        o_res0      = '0;
        o_res1      = '0;
        o_nres      = 2'd0;
        o_buf_we    = 1'b0;
        o_buf_waddr = i_state.load_index[BUF_AW-1:0];
        o_buf_wdata = i_item.tx_byte;

        unique case (i_item.func)
            FUNC_LOAD: begin
                if (i_state.load_index < MAX_PTR) begin
                    o_buf_we           = 1'b1;
                    o_state.load_index = i_state.load_index + PTR_W'(1);
                end
            end
            FUNC_START_WR, FUNC_START_RD: begin
                o_state.transfer_length = w_len;
                o_state.byte_pointer    = '0;
                o_state.load_index      = '0;
                if (i_item.func == FUNC_START_WR) begin
                    o_state.slave_address = i_item.address & ADDR_WR_MASK;
                    o_state.is_transmit   = 1'b1;
                end else begin
                    o_state.slave_address = i_item.address | ADDR_RD_BIT;
                    o_state.is_transmit   = 1'b0;
                    o_res0.pos_set        = (w_len == PTR_W'(2));
                end
                o_res0.ack_set   = 1'b1;
                o_res0.start_set = 1'b1;
                o_nres           = 2'd1;
            end
            FUNC_EVENT: begin
                priority if (i_item.flag_start) begin
                    o_res0.dr_write_valid = 1'b1;
                    o_res0.dr_value       = i_state.slave_address;
                    o_nres                = 2'd1;
                end else if (i_item.flag_addr) begin
                    if (i_state.is_transmit) begin
                        if (i_state.byte_pointer < MAX_PTR) begin
                            o_res0.dr_write_valid = 1'b1;
                            o_res0.dr_value       = i_buf_byte;
                            o_state.byte_pointer  = w_bp1;
                            o_nres                = 2'd1;
                        end
                    end else if (i_state.transfer_length == PTR_W'(1)) begin
                        o_res0.ack_clear = 1'b1;
                        o_res0.stop_set  = 1'b1;
                        o_res0.released  = 1'b1;
                        o_nres           = 2'd1;
                    end else if (i_state.transfer_length == PTR_W'(2)) begin
                        o_res0.ack_clear = 1'b1;
                        o_nres           = 2'd1;
                    end
                end else if (i_item.flag_btf) begin
                    if (i_state.is_transmit) begin
                        o_res0.stop_set      = 1'b1;
                        o_res0.released      = 1'b1;
                        o_state.byte_pointer = '0;
                        o_nres               = 2'd1;
                    end else begin
                        // Both data register reads of a BTF go out as two transfers.
                        o_res0.rx_valid = 1'b1;
                        o_res0.rx_byte  = i_item.data_reg;
                        o_res0.rx_index = i_state.byte_pointer[IDX_W-1:0];
                        o_res1.rx_valid = 1'b1;
                        o_res1.rx_byte  = i_item.data_reg_next;
                        o_res1.rx_index = w_bp1[IDX_W-1:0];
                        if (w_bp2 == i_state.transfer_length) begin
                            o_res1.ack_clear     = 1'b1;
                            o_res1.stop_set      = 1'b1;
                            o_res1.released      = 1'b1;
                            o_state.byte_pointer = '0;
                        end else begin
                            o_state.byte_pointer = w_bp2;
                        end
                        o_nres = 2'd2;
                    end
                end else if (i_item.flag_txe) begin
                    if (i_state.byte_pointer < i_state.transfer_length) begin
                        o_res0.dr_write_valid = 1'b1;
                        o_res0.dr_value       = i_buf_byte;
                        o_state.byte_pointer  = w_bp1;
                        o_nres                = 2'd1;
                    end
                end else if (i_item.flag_rxne) begin
                    o_res0.rx_valid      = 1'b1;
                    o_res0.rx_byte       = i_item.data_reg;
                    o_res0.rx_index      = i_state.byte_pointer[IDX_W-1:0];
                    o_state.byte_pointer = w_bp1;
                    if (w_bp1_plus == {1'b0, i_state.transfer_length}) begin
                        o_res0.ack_clear = 1'b1;
                        o_res0.stop_set  = 1'b1;
                    end else if (w_bp1 == i_state.transfer_length) begin
                        o_res0.released      = 1'b1;
                        o_state.byte_pointer = '0;
                    end
                    o_nres = 2'd1;
                end else begin
                    // An event with no flag set requests nothing.
                end
            end
            default: begin
            end
        endcase

        o_res0.last = (o_nres == 2'd1);
        o_res1.last = (o_nres == 2'd2);
    end

endmodule
`default_nettype wire
